FILE: rtl/scpc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// scpc_pkg
// Shared constants and types for the sine commutation position controller.
// ============================================================================
package scpc_pkg;

    // angles in 1/64 degree
    localparam int TURN_UNITS         = 23040;
    localparam int HALF_TURN_UNITS    = 11520;
    localparam int THIRD_TURN_UNITS   = 7680;
    localparam int QUARTER_TURN_UNITS = 5760;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // 1/((2n-1)(2n)) factors of the cosine series
    localparam longint unsigned TAYLOR_DIV [8] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240
    };

    localparam int COS_TABLE_ENTRIES_DEF = 1024;
    localparam int DUTY_WIDTH_DEF        = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ANGLE_OFFSET   = 3'd0,
        REG_POLE_PAIRS     = 3'd1,
        REG_KP_GAIN        = 3'd2,
        REG_VQ_LIMIT       = 3'd3,
        REG_SUPPLY_VOLTAGE = 3'd4,
        REG_PWM_PERIOD     = 3'd5
    } cfg_reg_t;

    localparam logic [14:0] ANGLE_OFFSET_RST   = 15'd15236;
    localparam logic [6:0]  POLE_PAIRS_RST     = 7'd11;
    localparam logic [15:0] KP_GAIN_RST        = 16'd256;
    localparam logic [14:0] VQ_LIMIT_RST       = 15'd24576;
    localparam logic [15:0] SUPPLY_VOLTAGE_RST = 16'd49152;
    localparam logic [15:0] PWM_PERIOD_RST     = 16'd1000;

endpackage

FILE: rtl/sine_commutation_position_p_control.sv
`timescale 1ns / 1ps
// ============================================================================
// sine_commutation_position_p_control
// P position control with sinusoidal three-phase PWM commutation.
// ============================================================================
//  channel  | direction | handshake                   | payload
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | mech_angle, angle_error
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | duty_a/b/c, drive_voltage
//  cfg      | in        | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
//  One word per cycle sustained while the output is not stalled; the 16-step
//  restoring divider (one quotient bit a stage) sits behind the cosine lookup.
//  Reset restores register defaults and empties the pipe; the cosine table
//  is a constant and needs no fill. A stalled output holds only the stages
//  that are full behind it, bubbles keep closing up.
// ============================================================================
module sine_commutation_position_p_control #(
    parameter int COS_TABLE_ENTRIES = scpc_pkg::COS_TABLE_ENTRIES_DEF,
    parameter int DUTY_WIDTH        = scpc_pkg::DUTY_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // mech_angle[14:0], angle_error[30:15], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // duty_a, duty_b, duty_c, drive_voltage
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [scpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [scpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int NS     = 30;
    localparam int DIV0   = 13;
    localparam int IDX_W  = $clog2(COS_TABLE_ENTRIES);
    localparam longint unsigned IDX_MUL =
        ((64'd1 << 30) * COS_TABLE_ENTRIES + 64'd23039) / 64'd23040;
    localparam logic [14:0] IDX_MUL_LO = 15'(IDX_MUL & 64'h7FFF);
    localparam logic [14:0] IDX_MUL_HI = 15'(IDX_MUL >> 15);
    localparam logic [16:0] DUTY_CAP   =
        (DUTY_WIDTH >= 16) ? 17'h0FFFF : 17'((64'd1 << DUTY_WIDTH) - 64'd1);

    typedef logic signed [15:0] rom_t [COS_TABLE_ENTRIES];

    function automatic logic signed [15:0] cos_q14(longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        int              n;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (n = 0; n < 8; n++)
        begin
            term = ((term * x2) >> 30) / scpc_pkg::TAYLOR_DIV[n];
            if (n[0] == 1'b0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum >= 0)
            return 16'((sum + 64'sd32768) >>> 16);
        return -16'(((-sum) + 64'sd32768) >>> 16);
    endfunction

    function automatic rom_t build_rom();
        rom_t            rom;
        longint unsigned m;
        longint unsigned x;
        int              k;
        for (k = 0; k < COS_TABLE_ENTRIES; k++)
        begin
            m = (k <= COS_TABLE_ENTRIES - k) ? longint'(k)
                                              : longint'(COS_TABLE_ENTRIES - k);
            if (4 * m > COS_TABLE_ENTRIES)
            begin
                x = (scpc_pkg::PI_Q30 * (COS_TABLE_ENTRIES - 2 * m)) / COS_TABLE_ENTRIES;
                rom[k] = -cos_q14(x);
            end
            else
            begin
                x = (2 * scpc_pkg::PI_Q30 * m) / COS_TABLE_ENTRIES;
                rom[k] = cos_q14(x);
            end
        end
        return rom;
    endfunction

    localparam rom_t COS_ROM = build_rom();

    // ------------------------------------------------------------ config
    logic [14:0]        angle_offset_reg;
    logic [6:0]         pole_pairs_reg;
    logic signed [15:0] kp_gain_reg;
    logic [14:0]        vq_limit_reg;
    logic [15:0]        supply_voltage_reg;
    logic [15:0]        pwm_period_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_offset_reg   <= scpc_pkg::ANGLE_OFFSET_RST;
            pole_pairs_reg     <= scpc_pkg::POLE_PAIRS_RST;
            kp_gain_reg        <= scpc_pkg::KP_GAIN_RST;
            vq_limit_reg       <= scpc_pkg::VQ_LIMIT_RST;
            supply_voltage_reg <= scpc_pkg::SUPPLY_VOLTAGE_RST;
            pwm_period_reg     <= scpc_pkg::PWM_PERIOD_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                scpc_pkg::REG_ANGLE_OFFSET:   angle_offset_reg   <= cfg_data[14:0];
                scpc_pkg::REG_POLE_PAIRS:     pole_pairs_reg     <= cfg_data[6:0];
                scpc_pkg::REG_KP_GAIN:        kp_gain_reg        <= cfg_data;
                scpc_pkg::REG_VQ_LIMIT:       vq_limit_reg       <= cfg_data[14:0];
                scpc_pkg::REG_SUPPLY_VOLTAGE: supply_voltage_reg <= cfg_data;
                scpc_pkg::REG_PWM_PERIOD:     pwm_period_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ flow
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    // a stage moves when it is empty or everything after it can move
    for (genvar k = 0; k < NS; k++)
    begin : g_en
        assign en[k] = m_axis_tready | ~(&v_reg[NS-1:k]);
    end

    assign v_next        = {v_reg[NS-2:0], s_axis_tvalid};
    assign s_axis_tready = en[0];
    assign m_axis_tvalid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_next[k];
            end
        end
    end

    // ------------------------------------------------------------ stage 0
    logic signed [15:0] err_in;
    logic signed [15:0] err_next;
    logic signed [16:0] diff_next;
    logic signed [15:0] err_reg;
    logic signed [16:0] diff_reg;

    assign err_in = $signed(s_axis_tdata[30:15]);

    always_comb
    begin
        err_next = err_in;
        if (err_in > 16'sd11520)
            err_next = err_in - 16'sd23040;
        else if (err_in < -16'sd11520)
            err_next = err_in + 16'sd23040;
        diff_next = $signed({2'b00, s_axis_tdata[14:0]}) - $signed({2'b00, angle_offset_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            err_reg  <= err_next;
            diff_reg <= diff_next;
        end
    end

    // ------------------------------------------------------------ stage 1
    logic signed [31:0] eprod_reg;
    logic signed [24:0] tprod_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            eprod_reg <= kp_gain_reg * err_reg;
            tprod_reg <= 25'(diff_reg * $signed({1'b0, pole_pairs_reg}));
        end
    end

    // ------------------------------------------------------------ stage 2
    // drive clamp; angle split as 512 * (v >> 9) so only a mod 45 is left
    logic signed [29:0] ediv4;
    logic signed [15:0] lim_s;
    logic signed [15:0] drive_next;
    logic signed [24:0] tv;
    logic signed [15:0] thi;
    logic [14:0]        u_next;
    logic [8:0]         lo9_reg [2:4];
    logic [14:0]        u_reg;
    logic signed [15:0] drv_reg [2:NS-1];

    always_comb
    begin
        ediv4 = 30'(eprod_reg >>> 2);
        lim_s = $signed({1'b0, vq_limit_reg});
        if (ediv4 > 30'(lim_s))
            drive_next = lim_s;
        else if (ediv4 < -30'(lim_s))
            drive_next = -lim_s;
        else
            drive_next = 16'(ediv4);
        tv     = tprod_reg + 25'sd5760;
        thi    = 16'(tv >>> 9) + 16'sd9000;
        u_next = thi[14:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            drv_reg[2] <= drive_next;
            lo9_reg[2] <= tv[8:0];
            u_reg      <= u_next;
        end
    end

    for (genvar k = 3; k < NS; k++)
    begin : g_drv
        always_ff @(posedge clk)
        begin
            if (en[k])
                drv_reg[k] <= drv_reg[k-1];
        end
    end

    // ------------------------------------------------------------ stage 3
    logic [29:0] qm_reg;
    logic [14:0] u3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            qm_reg     <= u_reg * 15'd23302;
            u3_reg     <= u_reg;
            lo9_reg[3] <= lo9_reg[2];
        end
    end

    // ------------------------------------------------------------ stage 4
    logic [9:0]  q45;
    logic [14:0] r45;
    logic [14:0] t_next;
    logic [14:0] t_reg;

    always_comb
    begin
        q45    = qm_reg[29:20];
        r45    = u3_reg - 15'(q45 * 6'd45);
        t_next = {r45[5:0], lo9_reg[3]};
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
            t_reg <= t_next;
    end

    // lo9 slot at stage 4 keeps the chain regular and feeds stage 5
    always_ff @(posedge clk)
    begin
        if (en[4])
            lo9_reg[4] <= lo9_reg[3];
    end

    // ------------------------------------------------------------ stage 5
    logic [2:0][14:0] tp_next;
    logic [2:0][14:0] tp_reg;

    always_comb
    begin
        tp_next[0] = t_reg;
        tp_next[1] = (t_reg >= 15'd7680) ? t_reg - 15'd7680 : t_reg + 15'd15360;
        tp_next[2] = (t_reg >= 15'd15360) ? t_reg - 15'd15360 : t_reg + 15'd7680;
        // fold in the spare lo9 copy: it equals t_reg's low bits by construction
        tp_next[0][8:0] = lo9_reg[4];
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
            tp_reg <= tp_next;
    end

    // ------------------------------------------------------------ stages 6..11
    logic [2:0][29:0]        pl_reg;
    logic [2:0][29:0]        phh_reg;
    logic [2:0][IDX_W-1:0]   idx_reg;
    logic [2:0][15:0]        cos_reg;
    logic [2:0][31:0]        dc_reg;
    logic [2:0][15:0]        ph16_reg;
    logic [2:0][31:0]        num_reg;
    logic [2:0]              np_reg [10:NS-2];
    logic [2:0][45:0]        isum;
    logic [2:0][17:0]        phase;

    always_comb
    begin
        for (int p = 0; p < 3; p++)
        begin
            isum[p]  = (46'(phh_reg[p]) << 15) + 46'(pl_reg[p]);
            phase[p] = 18'($signed(dc_reg[p]) >>> 14)
                     + $signed({2'b00, 1'b0, supply_voltage_reg[15:1]});
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < 3; p++)
        begin
            if (en[6])
            begin
                pl_reg[p]  <= tp_reg[p] * IDX_MUL_LO;
                phh_reg[p] <= tp_reg[p] * IDX_MUL_HI;
            end
            if (en[7])
                idx_reg[p] <= isum[p][30 +: IDX_W];
            if (en[8])
                cos_reg[p] <= COS_ROM[idx_reg[p]];
            if (en[9])
                dc_reg[p] <= 32'(drv_reg[8] * $signed(cos_reg[p]));
            if (en[10])
            begin
                np_reg[10][p] <= ($signed(phase[p]) <= 18'sd0);
                ph16_reg[p]   <= phase[p][15:0];
            end
            if (en[11])
                num_reg[p] <= pwm_period_reg * ph16_reg[p];
        end
    end

    for (genvar k = 11; k < NS-1; k++)
    begin : g_np
        always_ff @(posedge clk)
        begin
            if (en[k])
                np_reg[k] <= np_reg[k-1];
        end
    end

    // ------------------------------------------------------------ divider
    // restoring, one quotient bit a stage; quotient of 2^16 or more saturates
    logic [2:0][15:0] dr_reg [DIV0-1:DIV0+15];
    logic [2:0][15:0] dl_reg [DIV0-1:DIV0+15];
    logic [2:0][15:0] dq_reg [DIV0-1:DIV0+15];
    logic [2:0]       ov_reg [DIV0-1:DIV0+15];

    always_ff @(posedge clk)
    begin
        if (en[DIV0-1])
        begin
            for (int p = 0; p < 3; p++)
            begin
                dr_reg[DIV0-1][p] <= num_reg[p][31:16];
                dl_reg[DIV0-1][p] <= num_reg[p][15:0];
                dq_reg[DIV0-1][p] <= '0;
                ov_reg[DIV0-1][p] <= (num_reg[p][31:16] >= supply_voltage_reg);
            end
        end
    end

    for (genvar k = DIV0; k < DIV0 + 16; k++)
    begin : g_div
        localparam int B = DIV0 + 15 - k;
        logic [2:0][16:0] rem17;
        logic [2:0][15:0] dr_next;
        logic [2:0][15:0] dq_next;

        always_comb
        begin
            for (int p = 0; p < 3; p++)
            begin
                rem17[p]   = {dr_reg[k-1][p], dl_reg[k-1][p][B]};
                dr_next[p] = rem17[p][15:0];
                dq_next[p] = dq_reg[k-1][p];
                if (rem17[p] >= {1'b0, supply_voltage_reg})
                begin
                    dr_next[p]    = 16'(rem17[p] - {1'b0, supply_voltage_reg});
                    dq_next[p][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                dr_reg[k] <= dr_next;
                dl_reg[k] <= dl_reg[k-1];
                dq_reg[k] <= dq_next;
                ov_reg[k] <= ov_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------ output
    logic [15:0]      duty_lim;
    logic [2:0][15:0] duty_next;
    logic [2:0][15:0] duty_reg;

    always_comb
    begin
        duty_lim = ({1'b0, pwm_period_reg} < DUTY_CAP) ? pwm_period_reg : DUTY_CAP[15:0];
        for (int p = 0; p < 3; p++)
        begin
            if (np_reg[NS-2][p])
                duty_next[p] = '0;
            else if (ov_reg[NS-2][p] || dq_reg[NS-2][p] > duty_lim)
                duty_next[p] = duty_lim;
            else
                duty_next[p] = dq_reg[NS-2][p];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
            duty_reg <= duty_next;
    end

    assign m_axis_tdata = {drv_reg[NS-1], duty_reg[2], duty_reg[1], duty_reg[0]};

endmodule
